/* design/pbnp_pkg.sv */
// Shared constants, codes and control types for the path bisection nearest-point unit.
`timescale 1ns / 1ps

package pbnp_pkg;

	// Store geometry
	localparam int MAX_POINTS = 4096;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = ADDR_W + 1;

	// Field widths
	localparam int COORD_W  = 31;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 12;
	localparam int HELD_W   = 13;
	localparam int WORD_W   = 3 * COORD_W;
	localparam int SQ_W     = 2 * COORD_W;
	localparam int DIST_W   = SQ_W + 1;

	// Bisection stops once the span holds this many points or fewer
	localparam int SPAN_LIMIT = 3;

	// Opcodes
	localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic load_item;   // finish an item that needs no search and load the result register
		logic start_query; // latch query point, open span over the whole path
		logic rd_last;     // read address is the span's last point
		logic cap_first;   // capture distance to the span's first point
		logic step;        // compare distances and halve the span
		logic emit_found;  // load result from the span's first point
	} pbnp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic count_zero;
		logic span_big;
	} pbnp_sts_t;

endpackage

/* design/pbnp_if.sv */
// Request and response channel interfaces of the path bisection nearest-point unit.
`timescale 1ns / 1ps

interface pbnp_req_if import pbnp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           opcode;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;

	modport source(output valid, output opcode, output pos_x, output pos_y, output pos_z,
		input ready);
	modport sink(input valid, input opcode, input pos_x, input pos_y, input pos_z,
		output ready);
endinterface

interface pbnp_rsp_if import pbnp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] height_out;
	logic [INDEX_W-1:0]        found_index;
	logic [STATUS_W-1:0]       status;
	logic [HELD_W-1:0]         points_held;

	modport source(output valid, output height_out, output found_index, output status,
		output points_held, input ready);
	modport sink(input valid, input height_out, input found_index, input status,
		input points_held, output ready);
endinterface

/* design/pbnp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pbnp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/pbnp_ctrl.sv */
// Controller state machine: handshakes and sequencing of the bisection steps.
`timescale 1ns / 1ps

module pbnp_ctrl import pbnp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic [OP_W-1:0] req_opcode,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  pbnp_sts_t       sts,
	output pbnp_cmd_t       cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_RD_F   = 4'd2;
	localparam logic [3:0] S_RD_L   = 4'd3;
	localparam logic [3:0] S_P1     = 4'd4;
	localparam logic [3:0] S_P2     = 4'd5;
	localparam logic [3:0] S_CAPF   = 4'd6;
	localparam logic [3:0] S_DEC    = 4'd7;
	localparam logic [3:0] S_RD_Z   = 4'd8;
	localparam logic [3:0] S_WAIT_Z = 4'd9;

	logic [3:0] state_q, state_d;
	logic       rsp_valid_q;
	logic       accept;

	// Take an item only when idle and the result slot is free or draining
	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_opcode == OP_QUERY && !sts.count_zero) begin
						cmd.start_query = 1'b1;
						state_d         = S_CHECK;
					end else begin
						cmd.load_item = 1'b1;
					end
				end
			end
			S_CHECK:  state_d = sts.span_big ? S_RD_F : S_RD_Z;
			S_RD_F:   state_d = S_RD_L;
			S_RD_L: begin
				cmd.rd_last = 1'b1;
				state_d     = S_P1;
			end
			S_P1:     state_d = S_P2;
			S_P2:     state_d = S_CAPF;
			S_CAPF: begin
				cmd.cap_first = 1'b1;
				state_d       = S_DEC;
			end
			S_DEC: begin
				cmd.step = 1'b1;
				state_d  = S_CHECK;
			end
			S_RD_Z:   state_d = S_WAIT_Z;
			S_WAIT_Z: begin
				cmd.emit_found = 1'b1;
				state_d        = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// State and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_item || cmd.emit_found) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// A query result never lands on a result that is still waiting
	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_found |-> !rsp_valid_q)
		else $error("query result overwrites a pending result");

	// While a query is in flight no further result is produced before it
	a_query_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_query |=> !rsp_valid_q)
		else $error("result valid while query in flight");

	// A waiting result holds until it is taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |=> rsp_valid_q)
		else $error("pending result dropped");

endmodule

/* design/pbnp_dp.sv */
// Datapath: waypoint store, span registers, squared-distance pipeline and result register.
`timescale 1ns / 1ps

module pbnp_dp import pbnp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [OP_W-1:0]            opcode,
	input  logic signed [COORD_W-1:0]  pos_x,
	input  logic signed [COORD_W-1:0]  pos_y,
	input  logic signed [COORD_W-1:0]  pos_z,
	input  pbnp_cmd_t                  cmd,
	output pbnp_sts_t                  sts,
	output logic signed [COORD_W-1:0]  height_out,
	output logic [INDEX_W-1:0]         found_index,
	output logic [STATUS_W-1:0]        status,
	output logic [HELD_W-1:0]          points_held
);

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          n_q;
	logic [ADDR_W-1:0]         lo_q;
	logic signed [COORD_W-1:0] qx_q, qy_q;
	logic                      full;
	logic                      we;
	logic [WORD_W-1:0]         wdata, rdata;
	logic [ADDR_W-1:0]         raddr, last_addr;
	logic signed [COORD_W-1:0] rd_x, rd_y, rd_z;
	logic signed [COORD_W:0]   dx, dy;
	logic [COORD_W-1:0]        mx, my;
	logic [COORD_W-1:0]        ax_s1, ay_s1;
	logic [SQ_W-1:0]           sqx_s2, sqy_s2;
	logic [DIST_W-1:0]         dist_s3, dfirst_q;
	logic [CNT_W-1:0]          half;

	assign full = (count_q == CNT_W'(MAX_POINTS));
	assign we   = cmd.load_item && (opcode == OP_APPEND) && !full;

	// Word layout: z, y, x from high to low
	assign wdata     = {pos_z, pos_y, pos_x};
	assign last_addr = lo_q + n_q[ADDR_W-1:0] - ADDR_W'(1);
	assign raddr     = cmd.rd_last ? last_addr : lo_q;

	pbnp_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_x = rdata[COORD_W-1:0];
	assign rd_y = rdata[2*COORD_W-1:COORD_W];
	assign rd_z = rdata[WORD_W-1:2*COORD_W];

	// Planar offsets and their magnitudes (a magnitude never exceeds 2^31 - 1)
	assign dx = {qx_q[COORD_W-1], qx_q} - {rd_x[COORD_W-1], rd_x};
	assign dy = {qy_q[COORD_W-1], qy_q} - {rd_y[COORD_W-1], rd_y};
	assign mx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
	assign my = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

	// Free-running distance pipeline: magnitude, square, sum
	always_ff @(posedge clk) begin
		ax_s1   <= mx;
		ay_s1   <= my;
		sqx_s2  <= ax_s1 * ax_s1;
		sqy_s2  <= ay_s1 * ay_s1;
		dist_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		if (cmd.cap_first) begin
			dfirst_q <= dist_s3;
		end
		if (cmd.start_query) begin
			qx_q <= pos_x;
			qy_q <= pos_y;
		end
	end

	assign half = n_q >> 1;

	// Path count and active span
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lo_q    <= '0;
			n_q     <= '0;
		end else begin
			if (we) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.load_item && opcode == OP_CLEAR) begin
				count_q <= '0;
			end
			if (cmd.start_query) begin
				lo_q <= '0;
				n_q  <= count_q;
			end else if (cmd.step) begin
				// First strictly farther: keep the upper half
				if (dfirst_q > dist_s3) begin
					lo_q <= lo_q + half[ADDR_W-1:0];
					n_q  <= n_q - half;
				end else begin
					n_q <= half;
				end
			end
		end
	end

	assign sts.count_zero = (count_q == '0);
	assign sts.span_big   = (n_q > CNT_W'(SPAN_LIMIT));

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.emit_found) begin
			height_out  <= rd_z;
			found_index <= INDEX_W'(lo_q);
			status      <= ST_OK;
			points_held <= HELD_W'(count_q);
		end else if (cmd.load_item) begin
			unique case (opcode)
				OP_APPEND: begin
					height_out <= pos_z;
					if (!full) begin
						found_index <= INDEX_W'(count_q);
						status      <= ST_OK;
						points_held <= HELD_W'(count_q + CNT_W'(1));
					end else begin
						found_index <= '0;
						status      <= ST_FULL;
						points_held <= HELD_W'(count_q);
					end
				end
				OP_CLEAR: begin
					height_out  <= '0;
					found_index <= '0;
					status      <= ST_OK;
					points_held <= '0;
				end
				OP_QUERY: begin
					// Only reached with an empty path
					height_out  <= pos_z;
					found_index <= '0;
					status      <= ST_EMPTY;
					points_held <= HELD_W'(count_q);
				end
				default: begin
					height_out  <= '0;
					found_index <= '0;
					status      <= ST_OK;
					points_held <= HELD_W'(count_q);
				end
			endcase
		end
	end

	// Span stays inside the stored path and never empties
	a_span_in_path: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (n_q != '0) && ({1'b0, lo_q} + n_q <= count_q))
		else $error("span left the stored path");

	// Count never passes capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("waypoint count above capacity");

	// Query point holds for the whole search
	a_query_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> $stable(qx_q) && $stable(qy_q))
		else $error("query point changed during search");

endmodule

/* design/path_bisection_nearest_point_unit.sv */
// Top level of the path bisection nearest-point unit: controller, datapath and channels.
//
//   channel  role  payload
//   -------  ----  -------------------------------------------------
//   req      sink  opcode, pos_x, pos_y, pos_z (append, clear, query)
//   rsp      src   height_out, found_index, status, points_held
//
// Append, clear, unused opcodes and queries on an empty path finish in the cycle they
// are taken; the result is valid the next cycle. Other queries run S halving steps
// (0 for up to three points, at most 11, and 11 for a full path of 4096 points), then
// read the span's first point and load it as the result.
// Each step costs two reads on the store's single read port plus the three-stage
// distance pipeline before the compare. One item is worked on at a time.
// Reset clears the point count, the span and the control state; the store is not swept.
// A stalled result holds; a new item is taken when idle and the result slot is free or draining.
`timescale 1ns / 1ps

module path_bisection_nearest_point_unit import pbnp_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	pbnp_req_if.sink    req,
	pbnp_rsp_if.source  rsp
);

	pbnp_cmd_t cmd;
	pbnp_sts_t sts;

	pbnp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_opcode(req.opcode),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pbnp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.opcode     (req.opcode),
		.pos_x      (req.pos_x),
		.pos_y      (req.pos_y),
		.pos_z      (req.pos_z),
		.cmd        (cmd),
		.sts        (sts),
		.height_out (rsp.height_out),
		.found_index(rsp.found_index),
		.status     (rsp.status),
		.points_held(rsp.points_held)
	);

endmodule
